### rtl/pol_pkg.sv
// ============================================================================
// pol_pkg: shared types and constants for the positional ordered list
// Holds the list geometry, the command and status codes, and the control
// structures passed from the controller to the storage cells and the output stage.
// ============================================================================
`default_nettype none

package pol_pkg;

  localparam int CAPACITY   = 16;
  localparam int DATA_WIDTH = 32;

  // Widths of the transaction fields.
  localparam int CMD_W    = 2;
  localparam int POS_W    = 5;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int ECOUNT_W = 5;

  // The count must hold CAPACITY itself.
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_READ   = 2'd1,
    CMD_REMOVE = 2'd2
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE  = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Shift command broadcast to every cell of the chain.
  typedef struct packed {
    logic                  ins;
    logic                  rem;
    logic [DATA_WIDTH-1:0] data;
  } pol_shift_t;

  // Outcome of one command as seen by the output stage.
  typedef struct packed {
    status_t          status;
    logic             rd_ok;
    logic [CNT_W-1:0] count_next;
  } pol_result_t;

endpackage

`default_nettype wire

### rtl/positional_ordered_list_top.sv
// ============================================================================
// positional_ordered_list_top: insert, read and remove by list position
// The result transaction is registered: it appears in the cycle after its command is accepted.
// Throughput: one command per cycle while the result side does not stall.
// Reset clears the count and output valid; entries are left uncleared.
// ============================================================================
`default_nettype none

module positional_ordered_list_top (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [pol_pkg::CMD_W-1:0]    command,
  input  wire logic [pol_pkg::POS_W-1:0]    position,
  input  wire logic [pol_pkg::VALUE_W-1:0]  item_value,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic      [pol_pkg::STATUS_W-1:0] status,
  output logic      [pol_pkg::VALUE_W-1:0]  read_value,
  output logic      [pol_pkg::ECOUNT_W-1:0] entry_count
);

  logic                            accept;
  pol_pkg::pol_shift_t             shift;
  logic [pol_pkg::CAPACITY-1:0]    sel;
  logic [pol_pkg::CAPACITY-1:0]    ge;
  pol_pkg::pol_result_t            result;
  logic [pol_pkg::CNT_W-1:0]       count;
  logic [pol_pkg::DATA_WIDTH-1:0]  cell_data [pol_pkg::CAPACITY];
  logic [pol_pkg::DATA_WIDTH-1:0]  cell_tap  [pol_pkg::CAPACITY];
  logic [pol_pkg::DATA_WIDTH-1:0]  read_word;

  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  pol_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .command    (command),
    .position   (position),
    .item_value (item_value),
    .shift      (shift),
    .sel        (sel),
    .ge         (ge),
    .result     (result),
    .count      (count)
  );

  for (genvar g = 0; g < pol_pkg::CAPACITY; g++) begin : g_cell
    // The chain ends feed back their own word; the first cell never takes its left input.
    pol_cell u_cell (
      .clk        (clk),
      .shift      (shift),
      .sel        (sel[g]),
      .ge         (ge[g]),
      .left_data  (cell_data[(g == 0) ? 0 : g - 1]),
      .right_data (cell_data[(g == pol_pkg::CAPACITY - 1) ? g : g + 1]),
      .data       (cell_data[g]),
      .tap        (cell_tap[g])
    );
  end

  always_comb begin
    read_word = '0;
    for (int i = 0; i < pol_pkg::CAPACITY; i++) begin
      read_word = read_word | cell_tap[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status      <= result.status;
      read_value  <= result.rd_ok ? pol_pkg::VALUE_W'(read_word) : '0;
      entry_count <= pol_pkg::ECOUNT_W'(result.count_next);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= pol_pkg::CNT_W'(pol_pkg::CAPACITY))
    else $error("entry count exceeds capacity");

  a_accept_gives_result: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid)
    else $error("accepted command produced no result");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    accept && command == pol_pkg::CMD_INSERT && result.status == pol_pkg::ST_DONE
    |=> count == $past(count) + pol_pkg::CNT_W'(1))
    else $error("successful insert did not grow the list by one");

  a_read_zero_on_fail: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != pol_pkg::ST_DONE |-> read_value == '0)
    else $error("failed command returned nonzero read data");

endmodule

`default_nettype wire

### rtl/pol_cell.sv
// ============================================================================
// pol_cell: one storage cell of the list chain
// Holds one entry. On insert a cell at or after the position takes its left
// neighbor (or the new word at the position); on remove it takes its right
// neighbor. It also offers its word when selected for a read.
// ============================================================================
`default_nettype none

module pol_cell (
  input  wire logic                           clk,
  input  wire pol_pkg::pol_shift_t            shift,
  input  wire logic                           sel,
  input  wire logic                           ge,
  input  wire logic [pol_pkg::DATA_WIDTH-1:0] left_data,
  input  wire logic [pol_pkg::DATA_WIDTH-1:0] right_data,
  output logic      [pol_pkg::DATA_WIDTH-1:0] data,
  output logic      [pol_pkg::DATA_WIDTH-1:0] tap
);

  always_ff @(posedge clk) begin
    if (shift.ins && ge) begin
      data <= sel ? shift.data : left_data;
    end else if (shift.rem && ge) begin
      data <= right_data;
    end
  end

  assign tap = sel ? data : '0;

endmodule

`default_nettype wire

### rtl/pol_ctrl.sv
// ============================================================================
// pol_ctrl: command decode and entry count for the positional ordered list
// Checks the position against the count, decides the status, decodes the
// position into a select and an at-or-after mask for the cells, and keeps
// the entry count.
// ============================================================================
`default_nettype none

module pol_ctrl (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           accept,
  input  wire logic [pol_pkg::CMD_W-1:0]      command,
  input  wire logic [pol_pkg::POS_W-1:0]      position,
  input  wire logic [pol_pkg::VALUE_W-1:0]    item_value,
  output pol_pkg::pol_shift_t                 shift,
  output logic      [pol_pkg::CAPACITY-1:0]   sel,
  output logic      [pol_pkg::CAPACITY-1:0]   ge,
  output pol_pkg::pol_result_t                result,
  output logic      [pol_pkg::CNT_W-1:0]      count
);

  logic [pol_pkg::CNT_W-1:0] count_next;
  logic [pol_pkg::CMP_W-1:0] pos_c;
  logic [pol_pkg::CMP_W-1:0] cnt_c;
  logic                      in_range;
  logic                      ins_ok;
  logic                      rem_ok;
  logic                      full;

  assign pos_c    = pol_pkg::CMP_W'(position);
  assign cnt_c    = pol_pkg::CMP_W'(count);
  assign in_range = pos_c < cnt_c;
  assign full     = count >= pol_pkg::CNT_W'(pol_pkg::CAPACITY);

  always_comb begin
    result.status = pol_pkg::ST_RANGE;
    result.rd_ok  = 1'b0;
    ins_ok        = 1'b0;
    rem_ok        = 1'b0;
    case (pol_pkg::cmd_t'(command))
      pol_pkg::CMD_INSERT: begin
        // The past-the-end check takes priority over the full check.
        if (pos_c > cnt_c) begin
          result.status = pol_pkg::ST_RANGE;
        end else if (full) begin
          result.status = pol_pkg::ST_FULL;
        end else begin
          result.status = pol_pkg::ST_DONE;
          ins_ok        = 1'b1;
        end
      end
      pol_pkg::CMD_READ: begin
        if (in_range) begin
          result.status = pol_pkg::ST_DONE;
          result.rd_ok  = 1'b1;
        end
      end
      pol_pkg::CMD_REMOVE: begin
        if (in_range) begin
          result.status = pol_pkg::ST_DONE;
          rem_ok        = 1'b1;
        end
      end
      default: begin
        result.status = pol_pkg::ST_RANGE;
      end
    endcase

    count_next = count;
    if (ins_ok) begin
      count_next = count + pol_pkg::CNT_W'(1);
    end else if (rem_ok) begin
      count_next = count - pol_pkg::CNT_W'(1);
    end
    result.count_next = count_next;
  end

  assign shift.ins  = accept && ins_ok;
  assign shift.rem  = accept && rem_ok;
  assign shift.data = pol_pkg::DATA_WIDTH'(item_value);

  always_comb begin
    for (int i = 0; i < pol_pkg::CAPACITY; i++) begin
      sel[i] = pol_pkg::CMP_W'(i) == pos_c;
      ge[i]  = pol_pkg::CMP_W'(i) >= pos_c;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (accept) begin
      count <= count_next;
    end
  end

endmodule

`default_nettype wire

### tb/tb.sv
// ============================================================================
// tb: self-checking testbench for positional_ordered_list_top
// Drives insert, read and remove commands through the valid/stall input
// channel, predicts every status, read word and entry count with a local
// model of the list, and checks each output transaction in order. Both
// channels idle and stall at random, with one long stretch that never idles.
// ============================================================================

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pol_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_ITEMS = 900;

  // Command code with no operation behind it.
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  typedef struct packed {
    status_t               status;
    logic [VALUE_W-1:0]    rdata;
    logic [ECOUNT_W-1:0]   count;
  } list_result_t;

  // Mirror of the list contents plus the queue of predicted responses.
  class list_scoreboard;
    logic [DATA_WIDTH-1:0] words [CAPACITY];
    int unsigned           fill;
    list_result_t          awaited [$];
    int unsigned           errors;
    int unsigned           checked;
    int unsigned           full_refusals;
    int unsigned           range_refusals;
    int unsigned           peak_fill;

    function new();
      fill = 0;
      errors = 0;
      checked = 0;
      full_refusals = 0;
      range_refusals = 0;
      peak_fill = 0;
    endfunction

    function int unsigned pending();
      return awaited.size();
    endfunction

    function void note_command(logic [CMD_W-1:0] cmd, logic [POS_W-1:0] pos,
                               logic [VALUE_W-1:0] val);
      list_result_t res;
      int unsigned  p;
      p = 32'(pos);
      res.status = ST_RANGE;
      res.rdata  = '0;
      case (cmd)
        CMD_INSERT: begin
          // The position check wins over the full check.
          if (p > fill) begin
            res.status = ST_RANGE;
          end else if (fill >= CAPACITY) begin
            res.status = ST_FULL;
          end else begin
            for (int i = fill; i > p; i--) words[i] = words[i-1];
            words[p] = val[DATA_WIDTH-1:0];
            fill++;
            res.status = ST_DONE;
          end
        end
        CMD_READ: begin
          if (p < fill) begin
            res.rdata  = VALUE_W'(words[p]);
            res.status = ST_DONE;
          end
        end
        CMD_REMOVE: begin
          if (p < fill) begin
            for (int i = p; i + 1 < fill; i++) words[i] = words[i+1];
            fill--;
            res.status = ST_DONE;
          end
        end
        default: res.status = ST_RANGE;
      endcase
      if (res.status == ST_FULL) full_refusals++;
      if (res.status == ST_RANGE) range_refusals++;
      if (fill > peak_fill) peak_fill = fill;
      res.count = ECOUNT_W'(fill);
      awaited.push_back(res);
    endfunction

    function void check_result(logic [STATUS_W-1:0] st, logic [VALUE_W-1:0] rd,
                               logic [ECOUNT_W-1:0] cnt);
      list_result_t want;
      if (awaited.size() == 0) begin
        errors++;
        $display("%0t: response with nothing outstanding: status %0d data %h count %0d",
                 $time, st, rd, cnt);
        return;
      end
      want = awaited.pop_front();
      checked++;
      if (st !== want.status) begin
        errors++;
        $display("%0t: status expected %0d actual %0d", $time, want.status, st);
      end
      if (rd !== want.rdata) begin
        errors++;
        $display("%0t: read_value expected %h actual %h", $time, want.rdata, rd);
      end
      if (cnt !== want.count) begin
        errors++;
        $display("%0t: entry_count expected %0d actual %0d", $time, want.count, cnt);
      end
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [CMD_W-1:0]    command = '0;
  logic [POS_W-1:0]    position = '0;
  logic [VALUE_W-1:0]  item_value = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [STATUS_W-1:0] status;
  logic [VALUE_W-1:0]  read_value;
  logic [ECOUNT_W-1:0] entry_count;

  list_scoreboard sb = new();
  bit             no_idle = 1'b0;
  int unsigned    cycles = 0;
  int unsigned    sent = 0;

  positional_ordered_list_top dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .command     (command),
    .position    (position),
    .item_value  (item_value),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .read_value  (read_value),
    .entry_count (entry_count)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d responses outstanding", $time, sb.pending());
      $display("tb NOT OK");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_result(status, read_value, entry_count);
  end

  always @(negedge clk) begin
    out_stall <= !no_idle && ($urandom_range(0, 99) < 9);
  end

  // Presents one transaction and holds it until the block takes it.
  task automatic send_command(logic [CMD_W-1:0] cmd, logic [POS_W-1:0] pos,
                              logic [VALUE_W-1:0] val);
    @(negedge clk);
    in_valid   <= 1'b1;
    command    <= cmd;
    position   <= pos;
    item_value <= val;
    forever begin
      @(posedge clk);
      if (!in_stall) break;
    end
    sb.note_command(cmd, pos, val);
    sent++;
  endtask

  task automatic idle_sender(int unsigned gap);
    @(negedge clk);
    in_valid <= 1'b0;
    repeat (gap - 1) @(negedge clk);
  endtask

  // After four percent of the commands, chosen at random, the sender goes idle for a random gap.
  task automatic maybe_idle();
    if (!no_idle && $urandom_range(0, 99) < 4) idle_sender($urandom_range(1, 4));
  endtask

  task automatic drain_responses();
    idle_sender(1);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  function automatic logic [VALUE_W-1:0] pick_value();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return $urandom;
  endfunction

  task automatic random_command(bit grow);
    int unsigned        r;
    logic [CMD_W-1:0]   cmd;
    logic [POS_W-1:0]   pos;
    int unsigned        f;
    f = sb.fill;
    r = $urandom_range(0, 99);
    if (r < 5)                     cmd = CMD_UNUSED;
    else if (r < (grow ? 60 : 35)) cmd = CMD_INSERT;
    else if (r < (grow ? 80 : 60)) cmd = CMD_READ;
    else                           cmd = CMD_REMOVE;
    // Mostly legal positions, with some anywhere in the field's range.
    if ($urandom_range(0, 99) < 15) begin
      pos = POS_W'($urandom_range(0, 31));
    end else if (cmd == CMD_INSERT) begin
      pos = POS_W'($urandom_range(0, f));
    end else begin
      pos = (f == 0) ? '0 : POS_W'($urandom_range(0, f - 1));
    end
    send_command(cmd, pos, pick_value());
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Empty list: everything but an insert at the head is refused.
    send_command(CMD_READ, 5'd0, 32'h0);
    send_command(CMD_REMOVE, 5'd0, 32'h0);
    send_command(CMD_INSERT, 5'd1, 32'h1234_5678);
    send_command(CMD_UNUSED, 5'd31, 32'hFFFF_FFFF);
    // Removing the only entry leaves an empty list.
    send_command(CMD_INSERT, 5'd0, 32'hA5A5_A5A5);
    send_command(CMD_REMOVE, 5'd0, 32'h0);
    // Fill to capacity, alternating head and tail inserts.
    for (int i = 0; i < CAPACITY; i++) begin
      if (i == 0)      send_command(CMD_INSERT, 5'd0, 32'h0);
      else if (i == 1) send_command(CMD_INSERT, 5'd0, 32'hFFFF_FFFF);
      else             send_command(CMD_INSERT, POS_W'(i[0] ? 0 : sb.fill), $urandom);
    end
    // Full list: a legal position reports full, an illegal one reports range.
    send_command(CMD_INSERT, 5'd16, 32'hDEAD_BEEF);
    send_command(CMD_INSERT, 5'd17, 32'hDEAD_BEEF);
    send_command(CMD_READ, 5'd15, 32'h0);
    send_command(CMD_READ, 5'd16, 32'h0);
    send_command(CMD_REMOVE, 5'd15, 32'h0);
    send_command(CMD_REMOVE, 5'd31, 32'h0);
    send_command(CMD_READ, 5'd0, 32'h0);

    drain_responses();

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      no_idle = (n >= 300 && n < 500);
      if (n == 650) drain_responses();
      // Swing between growing and shrinking so the fill level sweeps its range.
      random_command(((n / 60) % 2) == 0);
      maybe_idle();
    end
    no_idle = 1'b0;

    drain_responses();
    repeat (4) @(posedge clk);

    $display("Sent %0d commands and checked %0d responses; peak fill %0d of %0d.",
             sent, sb.checked, sb.peak_fill, CAPACITY);
    $display("Refusals seen: %0d out of range, %0d on a full list.",
             sb.range_refusals, sb.full_refusals);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
